// ===== rtl/hcbp_pkg.sv =====
// Shared constants, request codes and beat types of the Huffman codeword bit packer.
package hcbp_pkg;

   // Field widths of the request and response beats
   localparam int REQ_TYPE_W   = 2;
   localparam int SYMBOL_W     = 8;
   localparam int CODE_FIELD_W = 32;
   localparam int CODE_LEN_W   = 6;
   localparam int BYTE_W       = 8;
   localparam int SPARE_W      = 3;

   // Pending bit buffer holds at most one byte less one bit
   localparam int PEND_W       = 7;
   localparam int PEND_CNT_W   = 3;

   // Code table
   localparam int TABLE_DEPTH  = 256;
   localparam int MAX_CODE_LEN = 32;

   // Request codes
   localparam logic [REQ_TYPE_W-1:0] REQ_LOAD   = 2'd0;
   localparam logic [REQ_TYPE_W-1:0] REQ_ENCODE = 2'd1;
   localparam logic [REQ_TYPE_W-1:0] REQ_FLUSH  = 2'd2;

   typedef struct packed {
      logic [REQ_TYPE_W-1:0]   req_type;
      logic [SYMBOL_W-1:0]     symbol;
      logic [CODE_FIELD_W-1:0] code_bits;
      logic [CODE_LEN_W-1:0]   code_len;
   } req_beat_type;

   typedef struct packed {
      logic [BYTE_W-1:0]  out_byte;
      logic               byte_valid;
      logic               is_final;
      logic [SPARE_W-1:0] pad_count;
      logic               code_missing;
      logic               last;
   } rsp_beat_type;

endpackage

// ===== rtl/hcbp_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
module hcbp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/huffman_codeword_bit_packer.sv =====
// Top level of the Huffman codeword bit packer: code table, bit buffer and byte emitter.
// Usage:
//   Request channel (req_valid / req_stall / req_beat) carries three kinds of beat:
//   load writes a codeword and its length into the 256-entry code table and gives
//   no response; encode looks up the symbol's codeword, appends it to the pending
//   bits and gives one response beat per completed byte (none if no byte
//   completes, one with code_missing set if the symbol has no code); flush pads
//   the pending bits with zeros and gives one response beat with is_final set.
//   Response channel (rsp_valid / rsp_stall / rsp_beat) moves one byte a beat;
//   last marks the final beat caused by a request.
// Timing:
//   A request is taken into the lookup stage (table read register), is then handed
//   to the emitter and its first response beat then enters the output register.
//   The emitter sends one beat per cycle while the output is not stalled, so an
//   encode occupies it for one beat per completed byte (one to four at 32-bit
//   codes); requests without a response pass at one per cycle.
// Reset clears the pending bits, the table's valid bits (all codes missing) and
// all pipeline valids. While rsp_stall is high the output beat holds and the
// stall backs up through the emitter and lookup stage to req_stall.
module huffman_codeword_bit_packer #(
   parameter int MAX_CODE_LEN = hcbp_pkg::MAX_CODE_LEN
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  hcbp_pkg::req_beat_type req_beat,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output hcbp_pkg::rsp_beat_type rsp_beat
);

   // Stored code width, saturated to the request field
   localparam int CW      = (MAX_CODE_LEN < hcbp_pkg::CODE_FIELD_W) ?
                            MAX_CODE_LEN : hcbp_pkg::CODE_FIELD_W;
   localparam int LEN_W   = $clog2(CW + 1);
   localparam int ENT_W   = CW + LEN_W;
   localparam int ACC_W   = hcbp_pkg::PEND_W + CW;
   localparam int TOT_W   = $clog2(ACC_W + 1);
   localparam int MAXB    = ACC_W / hcbp_pkg::BYTE_W;
   localparam int CNT_W   = $clog2(MAXB + 1);
   localparam int BYTE_W  = hcbp_pkg::BYTE_W;
   localparam int PEND_W  = hcbp_pkg::PEND_W;
   localparam int PCNT_W  = hcbp_pkg::PEND_CNT_W;
   localparam int SPARE_W = hcbp_pkg::SPARE_W;

   // ---------------------------------------------------------------------
   // Request accept and table write
   // ---------------------------------------------------------------------
   logic              req_accept;
   logic              load_wr;
   logic [LEN_W-1:0]  load_len;
   logic [CW-1:0]     load_code;
   logic [ENT_W-1:0]  rd_entry;

   logic [hcbp_pkg::TABLE_DEPTH-1:0] table_vld_ff, table_vld_in;

   assign req_accept = req_valid && !req_stall;
   assign load_wr    = req_accept && (req_beat.req_type == hcbp_pkg::REQ_LOAD);

   // Saturate length and drop codeword bits at or above it
   always_comb begin
      if (req_beat.code_len > hcbp_pkg::CODE_LEN_W'(CW)) begin
         load_len = LEN_W'(CW);
      end else begin
         load_len = LEN_W'(req_beat.code_len);
      end
      load_code = req_beat.code_bits[CW-1:0] & ~({CW{1'b1}} << load_len);
   end

   hcbp_ram #(
      .WIDTH (ENT_W),
      .DEPTH (hcbp_pkg::TABLE_DEPTH)
   ) u_code_table (
      .clock   (clock),
      .wr_en   (load_wr),
      .wr_addr (req_beat.symbol),
      .wr_data ({load_len, load_code}),
      .rd_en   (req_accept),
      .rd_addr (req_beat.symbol),
      .rd_data (rd_entry)
   );

   // Mark entries as loaded
   always_comb begin
      table_vld_in = table_vld_ff;
      if (load_wr) begin
         table_vld_in[req_beat.symbol] = 1'b1;
      end
   end

   // ---------------------------------------------------------------------
   // Lookup stage
   // ---------------------------------------------------------------------
   logic                              s1_valid_ff, s1_valid_in;
   logic [hcbp_pkg::REQ_TYPE_W-1:0]   s1_kind_ff;
   logic                              s1_hit_ff;
   logic                              s1_go;
   logic                              s1_has_rsp;

   logic [PEND_W-1:0] pend_bits_ff, pend_bits_in;
   logic [PCNT_W-1:0] pend_cnt_ff, pend_cnt_in;

   logic [CW-1:0]      ent_code;
   logic [LEN_W-1:0]   ent_len;
   logic               missing;
   logic [ACC_W-1:0]   acc;
   logic [ACC_W-1:0]   acc_aligned;
   logic [TOT_W-1:0]   total;
   logic [CNT_W-1:0]   nbytes;
   logic [PCNT_W-1:0]  new_cnt;
   logic [PEND_W-1:0]  new_bits;
   logic [SPARE_W-1:0] spare;
   logic [BYTE_W-1:0]  pad_byte;

   assign ent_code = rd_entry[CW-1:0];
   assign ent_len  = rd_entry[ENT_W-1:CW];

   // Append the codeword to the pending bits and left-align the result
   always_comb begin
      missing     = !s1_hit_ff || (ent_len == '0);
      acc         = (ACC_W'(pend_bits_ff) << ent_len) | ACC_W'(ent_code);
      total       = TOT_W'(pend_cnt_ff) + TOT_W'(ent_len);
      nbytes      = CNT_W'(total >> 3);
      new_cnt     = total[PCNT_W-1:0];
      new_bits    = acc[PEND_W-1:0] & ~({PEND_W{1'b1}} << new_cnt);
      acc_aligned = acc << (TOT_W'(ACC_W) - total);
      spare       = SPARE_W'(4'(BYTE_W) - 4'(pend_cnt_ff));
      pad_byte    = BYTE_W'({1'b0, pend_bits_ff} << spare);
   end

   // Decide whether the item needs the emitter
   always_comb begin
      case (s1_kind_ff)
         hcbp_pkg::REQ_ENCODE: s1_has_rsp = missing || (nbytes != '0);
         hcbp_pkg::REQ_FLUSH:  s1_has_rsp = 1'b1;
         default:              s1_has_rsp = 1'b0;
      endcase
   end

   // ---------------------------------------------------------------------
   // Emitter
   // ---------------------------------------------------------------------
   logic               e_valid_ff, e_valid_in;
   logic [ACC_W-1:0]   e_data_ff, e_data_in;
   logic [CNT_W-1:0]   e_left_ff, e_left_in;
   logic               e_bv_ff, e_bv_in;
   logic               e_final_ff, e_final_in;
   logic [SPARE_W-1:0] e_spare_ff, e_spare_in;
   logic               e_miss_ff, e_miss_in;
   logic               e_free;
   logic               e_load;
   logic               out_move;
   logic               e_last;

   logic                   rsp_valid_ff, rsp_valid_in;
   hcbp_pkg::rsp_beat_type rsp_beat_ff, rsp_beat_in;

   assign e_last     = (e_left_ff == CNT_W'(1));
   assign out_move   = e_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign e_free     = !e_valid_ff || (out_move && e_last);
   assign s1_go      = s1_valid_ff && (!s1_has_rsp || e_free);
   assign e_load     = s1_go && s1_has_rsp;
   assign req_stall  = s1_valid_ff && !s1_go;
   assign s1_valid_in = req_accept ? 1'b1 : (s1_go ? 1'b0 : s1_valid_ff);

   // Update the pending buffer as an item leaves the lookup stage
   always_comb begin
      pend_bits_in = pend_bits_ff;
      pend_cnt_in  = pend_cnt_ff;
      if (s1_go) begin
         case (s1_kind_ff)
            hcbp_pkg::REQ_ENCODE: begin
               if (!missing) begin
                  pend_bits_in = new_bits;
                  pend_cnt_in  = new_cnt;
               end
            end
            hcbp_pkg::REQ_FLUSH: begin
               pend_bits_in = '0;
               pend_cnt_in  = '0;
            end
            default: begin
               pend_bits_in = pend_bits_ff;
               pend_cnt_in  = pend_cnt_ff;
            end
         endcase
      end
   end

   // Load the emitter from the lookup stage or advance it by one byte
   always_comb begin
      e_valid_in = e_valid_ff;
      e_data_in  = e_data_ff;
      e_left_in  = e_left_ff;
      e_bv_in    = e_bv_ff;
      e_final_in = e_final_ff;
      e_spare_in = e_spare_ff;
      e_miss_in  = e_miss_ff;
      if (e_load) begin
         e_valid_in = 1'b1;
         if (s1_kind_ff == hcbp_pkg::REQ_FLUSH) begin
            e_data_in  = ACC_W'(pad_byte) << (ACC_W - BYTE_W);
            e_left_in  = CNT_W'(1);
            e_bv_in    = (pend_cnt_ff != '0);
            e_final_in = 1'b1;
            e_spare_in = spare;
            e_miss_in  = 1'b0;
         end else if (missing) begin
            e_data_in  = '0;
            e_left_in  = CNT_W'(1);
            e_bv_in    = 1'b0;
            e_final_in = 1'b0;
            e_spare_in = '0;
            e_miss_in  = 1'b1;
         end else begin
            e_data_in  = acc_aligned;
            e_left_in  = nbytes;
            e_bv_in    = 1'b1;
            e_final_in = 1'b0;
            e_spare_in = '0;
            e_miss_in  = 1'b0;
         end
      end else if (out_move) begin
         e_data_in  = e_data_ff << BYTE_W;
         e_left_in  = e_left_ff - CNT_W'(1);
         e_valid_in = !e_last;
      end
   end

   // Output register: take a beat from the emitter, drop it once taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_beat_in  = rsp_beat_ff;
      if (out_move) begin
         rsp_valid_in             = 1'b1;
         rsp_beat_in.out_byte     = e_data_ff[ACC_W-1 -: BYTE_W];
         rsp_beat_in.byte_valid   = e_bv_ff;
         rsp_beat_in.is_final     = e_final_ff;
         rsp_beat_in.pad_count    = e_spare_ff;
         rsp_beat_in.code_missing = e_miss_ff;
         rsp_beat_in.last         = e_last;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         table_vld_ff <= '0;
         s1_valid_ff  <= 1'b0;
         e_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pend_bits_ff <= '0;
         pend_cnt_ff  <= '0;
      end else begin
         table_vld_ff <= table_vld_in;
         s1_valid_ff  <= s1_valid_in;
         e_valid_ff   <= e_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         pend_bits_ff <= pend_bits_in;
         pend_cnt_ff  <= pend_cnt_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_kind_ff <= req_beat.req_type;
         s1_hit_ff  <= table_vld_ff[req_beat.symbol];
      end
      e_data_ff   <= e_data_in;
      e_left_ff   <= e_left_in;
      e_bv_ff     <= e_bv_in;
      e_final_ff  <= e_final_in;
      e_spare_ff  <= e_spare_in;
      e_miss_ff   <= e_miss_in;
      rsp_beat_ff <= rsp_beat_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_beat  = rsp_beat_ff;

endmodule
